/* rtl/crc16_augmented_byte_stream_macros.svh */
// assertion macros used by the checker file
`ifndef CRC16_AUGMENTED_BYTE_STREAM_MACROS_SVH
`define CRC16_AUGMENTED_BYTE_STREAM_MACROS_SVH

// same-cycle implication, checked out of reset
`define CRC16AB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crc16ab check failed");

// next-cycle implication, checked out of reset
`define CRC16AB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crc16ab check failed");

`endif

/* rtl/crc16ab_pkg.sv */
`default_nettype none

package crc16ab_pkg;

    localparam int unsigned CRC_W      = 16;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned FLUSH_BITS = 16;

    localparam logic [CRC_W-1:0] POLY_RESET = 16'h1021;
    localparam logic [CRC_W-1:0] INIT_RESET = 16'h0000;

    typedef logic [CRC_W-1:0]  t_crc;
    typedef logic [BYTE_W-1:0] t_byte;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_POLYNOMIAL    = 1'b0,
        CFG_INITIAL_VALUE = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_crc polynomial;
        t_crc initial_value;
    } t_cfg;

    // request held in the input register
    typedef struct packed {
        logic  valid;
        logic  last_byte;
        t_byte data_byte;
    } t_item;

    // one shift of the augmented register
    function automatic t_crc crc_shift_bit(input t_crc reg_in, input logic bit_in,
                                           input t_crc poly);
        t_crc nxt;
        nxt = {reg_in[CRC_W-2:0], bit_in};
        if (reg_in[CRC_W-1]) begin
            nxt = nxt ^ poly;
        end
        return nxt;
    endfunction

    // eight data bits, most significant first
    function automatic t_crc crc_shift_byte(input t_crc reg_in, input t_byte data,
                                            input t_crc poly);
        t_crc acc;
        acc = reg_in;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            acc = crc_shift_bit(acc, data[i], poly);
        end
        return acc;
    endfunction

    // zero flush at message end
    function automatic t_crc crc_flush(input t_crc reg_in, input t_crc poly);
        t_crc acc;
        acc = reg_in;
        for (int i = 0; i < FLUSH_BITS; i++) begin
            acc = crc_shift_bit(acc, 1'b0, poly);
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

/* rtl/crc16ab_if.sv */
`default_nettype none

// message byte channel
interface crc16ab_byte_if;
    import crc16ab_pkg::*;
    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  last_byte;
    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// crc result channel
interface crc16ab_crc_if;
    import crc16ab_pkg::*;
    logic valid;
    logic ready;
    t_crc crc_value;
    logic is_final;
    modport source (output valid, output crc_value, output is_final, input ready);
    modport sink   (input valid, input crc_value, input is_final, output ready);
endinterface

// configuration write channel
interface crc16ab_cfg_if;
    import crc16ab_pkg::*;
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_crc     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/crc16_augmented_byte_stream.sv */
// Augmented CRC-16 over a byte stream, polynomial and seed configurable.
// i_byte: one message byte per request, most significant bit first;
//   last_byte marks the end of a message and adds the 16-bit zero flush.
// o_crc: one result per byte: the running register, or with is_final set
//   the finished message CRC. The register reseeds after a final byte.
// i_cfg: index 0 polynomial (reset 0x1021), index 1 initial value
//   (reset 0x0000); always ready, write only while the stream is idle.
// An accepted byte is held in the input register, then passes the shift
//   and flush network into the result register. Throughput is one byte
//   per cycle while o_crc does not stall, set by the XOR network that
//   also updates the running register.
// When o_crc stalls, one result waits in the result register and one
//   byte in the input register; i_byte.ready then drops until o_crc moves.
// Synchronous active-low reset empties both registers, restores the
//   configuration defaults and starts a fresh message.
`default_nettype none

module crc16_augmented_byte_stream (
    input  wire             i_clk,
    input  wire             i_rst_n,
    crc16ab_byte_if.sink    i_byte,
    crc16ab_cfg_if.sink     i_cfg,
    crc16ab_crc_if.source   o_crc
);
    import crc16ab_pkg::*;

    t_cfg  w_cfg;
    t_item w_item;
    logic  w_advance;

    // configuration registers
    crc16ab_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // input register
    crc16ab_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (i_byte),
        .i_advance (w_advance),
        .o_item    (w_item)
    );

    // crc network, running register and result register
    crc16ab_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (w_item),
        .i_cfg     (w_cfg),
        .o_crc     (o_crc),
        .o_advance (w_advance)
    );

endmodule

`default_nettype wire

/* rtl/crc16ab_cfg_regs.sv */
`default_nettype none

module crc16ab_cfg_regs (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    crc16ab_cfg_if.sink         i_cfg,
    output crc16ab_pkg::t_cfg   o_cfg
);
    import crc16ab_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // writes are always taken
    assign i_cfg.ready = 1'b1;

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_POLYNOMIAL:    n_cfg.polynomial    = i_cfg.data;
                CFG_INITIAL_VALUE: n_cfg.initial_value = i_cfg.data;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.polynomial    <= POLY_RESET;
            r_cfg.initial_value <= INIT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* rtl/crc16ab_in_reg.sv */
`default_nettype none

module crc16ab_in_reg (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    crc16ab_byte_if.sink         i_byte,
    input  wire                  i_advance,
    output crc16ab_pkg::t_item   o_item
);
    import crc16ab_pkg::*;

    t_item r_item;
    t_item n_item;
    logic  w_ready;

    // free, or emptying into the result register this cycle
    assign w_ready      = !r_item.valid || i_advance;
    assign i_byte.ready = w_ready;

    always_comb begin
        n_item = r_item;
        if (w_ready) begin
            n_item.valid     = i_byte.valid;
            n_item.data_byte = i_byte.data_byte;
            n_item.last_byte = i_byte.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else begin
            r_item.valid <= n_item.valid;
        end
        r_item.data_byte <= n_item.data_byte;
        r_item.last_byte <= n_item.last_byte;
    end

    assign o_item = r_item;

endmodule

`default_nettype wire

/* rtl/crc16ab_datapath.sv */
`default_nettype none

module crc16ab_datapath (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  crc16ab_pkg::t_item   i_item,
    input  crc16ab_pkg::t_cfg    i_cfg,
    crc16ab_crc_if.source        o_crc,
    output logic                 o_advance
);
    import crc16ab_pkg::*;

    logic r_out_valid;
    logic n_out_valid;
    t_crc r_crc;
    t_crc n_crc;
    logic r_final;
    logic n_final;
    t_crc r_shift;
    t_crc n_shift;
    logic r_in_msg;
    logic n_in_msg;

    t_crc w_start;
    t_crc w_data_res;
    t_crc w_flush_res;

    // result register can take a new request
    assign o_advance = !r_out_valid || o_crc.ready;

    // register at message start comes from the configured seed
    assign w_start     = r_in_msg ? r_shift : i_cfg.initial_value;
    assign w_data_res  = crc_shift_byte(w_start, i_item.data_byte, i_cfg.polynomial);
    assign w_flush_res = crc_flush(w_data_res, i_cfg.polynomial);

    // next state of result and running register
    always_comb begin
        n_out_valid = r_out_valid;
        n_crc       = r_crc;
        n_final     = r_final;
        n_shift     = r_shift;
        n_in_msg    = r_in_msg;
        if (o_advance) begin
            n_out_valid = i_item.valid;
            if (i_item.valid) begin
                n_crc    = i_item.last_byte ? w_flush_res : w_data_res;
                n_final  = i_item.last_byte;
                n_shift  = w_data_res;
                n_in_msg = !i_item.last_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_in_msg    <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_in_msg    <= n_in_msg;
        end
        r_crc   <= n_crc;
        r_final <= n_final;
        r_shift <= n_shift;
    end

    assign o_crc.valid     = r_out_valid;
    assign o_crc.crc_value = r_crc;
    assign o_crc.is_final  = r_final;

endmodule

`default_nettype wire

/* rtl/crc16ab_checker.sv */
`default_nettype none
`include "crc16_augmented_byte_stream_macros.svh"

module crc16ab_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [15:0] i_out_crc,
    input wire        i_out_final
);

    logic        w_in_acc;
    logic        w_out_stall;
    logic        w_out_free;
    logic [16:0] w_out_word;

    assign w_in_acc    = i_in_valid && i_in_ready;
    assign w_out_stall = i_out_valid && !i_out_ready;

    // result register empty or draining this cycle
    assign w_out_free  = !i_out_valid || i_out_ready;

    // whole result payload
    assign w_out_word  = {i_out_crc, i_out_final};

    // a stalled result holds
    `CRC16AB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, i_out_valid && $stable(w_out_word))

    // accepted byte passes the input register and shows as a result when the output drains
    `CRC16AB_ASSERT_NEXT(a_latency, i_clk, i_rst_n, w_in_acc ##1 w_out_free, i_out_valid)

    // an empty result register never holds back the input
    `CRC16AB_ASSERT_IMP(a_ready_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready)

endmodule

bind crc16_augmented_byte_stream crc16ab_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_byte.valid),
    .i_in_ready  (i_byte.ready),
    .i_out_valid (o_crc.valid),
    .i_out_ready (o_crc.ready),
    .i_out_crc   (o_crc.crc_value),
    .i_out_final (o_crc.is_final)
);

`default_nettype wire
